/* hdl/color_temperature_gamma_ramp_core_macros.svh */
// Assertion macros for the color temperature gamma ramp core.
// Included by files that check their own logic; no other dependencies.
`ifndef COLOR_TEMPERATURE_GAMMA_RAMP_CORE_MACROS_SVH
`define COLOR_TEMPERATURE_GAMMA_RAMP_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CTR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define CTR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define CTR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CTR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/ctr_pkg.sv */
// Shared types and constants of the color temperature gamma ramp core.
// No dependencies.
package ctr_pkg;

   localparam int IDX_W     = 12;
   localparam int LEVEL_W   = 16;
   localparam int KELVIN_W  = 14;
   localparam int RSIZE_W   = 13;
   localparam int GAIN_W    = 24;
   localparam int DIVISOR_W = 21;
   localparam int LANE_LAT  = 19;

   localparam int DIV_NUM_W = 47;
   localparam int DIV_DEN_W = 18;
   localparam int DIV_STEPS = 47;

   localparam logic [GAIN_W-1:0]   GAIN_MAX  = 24'd16711680;
   localparam logic [29:0]         LN2_Q30   = 30'd744261118;
   localparam logic [KELVIN_W-1:0] K_WARM    = 14'd6500;
   localparam logic [KELVIN_W-1:0] K_BLUE_LO = 14'd1900;
   localparam logic [KELVIN_W-1:0] K_RESET   = 14'd6500;
   localparam logic [RSIZE_W-1:0]  RSIZE_RESET = 13'd256;

   // ceil(2^33/25): kelvin*16384/25 exact for the full kelvin range
   localparam logic [28:0] KDIV25_RECIP = 29'd343597384;
   // reciprocals of the odd series terms, exact for 30-bit dividends
   localparam logic [30:0] RECIP_3 = 31'd1431655766;
   localparam logic [30:0] RECIP_5 = 31'd1717986919;
   localparam logic [30:0] RECIP_7 = 31'd1227133514;
   localparam logic [30:0] RECIP_9 = 31'd1908874354;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   localparam logic REG_KELVIN = 1'b0;
   localparam logic REG_RSIZE  = 1'b1;

   typedef struct packed {
      logic signed [29:0] a;
      logic signed [20:0] b;
      logic signed [27:0] c;
      logic [5:0]         off;
   } fit_type;

   localparam fit_type RED_FIT  = '{a: 30'sd369074536, b: 21'sd119754,
                                    c: -28'sd42209025, off: 6'd55};
   localparam fit_type GREEN_LO = '{a: -30'sd162796515, b: -21'sd467633,
                                    c: 28'sd109567973, off: 6'd2};
   localparam fit_type GREEN_HI = '{a: 30'sd341258443, b: 21'sd83293,
                                    c: -28'sd29449568, off: 6'd50};
   localparam fit_type BLUE_FIT = '{a: -30'sd267145028, b: 21'sd867602,
                                    c: 28'sd121299213, off: 6'd10};

   typedef struct packed {
      logic              ok;
      logic [GAIN_W-1:0] red;
      logic [GAIN_W-1:0] green;
      logic [GAIN_W-1:0] blue;
   } gains_type;

   typedef enum logic [11:0] {
      ST_CH    = 12'b000000000001,
      ST_TCALC = 12'b000000000010,
      ST_NORM  = 12'b000000000100,
      ST_ZDIV  = 12'b000000001000,
      ST_Z2    = 12'b000000010000,
      ST_PW    = 12'b000000100000,
      ST_KDIV  = 12'b000001000000,
      ST_LN    = 12'b000010000000,
      ST_MUL1  = 12'b000100000000,
      ST_MUL2  = 12'b001000000000,
      ST_SUM   = 12'b010000000000,
      ST_IDLE  = 12'b100000000000
   } gain_state_type;

endpackage

/* hdl/ctr_ifs.sv */
// Valid/ready channel interfaces for ramp index words and ramp entry words.
// Depends on ctr_pkg for field widths.
interface ctr_req_if import ctr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] ramp_index;
   modport source (output valid, output ramp_index, input ready);
   modport sink   (input valid, input ramp_index, output ready);
endinterface

interface ctr_rsp_if import ctr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] red_level;
   logic [LEVEL_W-1:0] green_level;
   logic [LEVEL_W-1:0] blue_level;
   modport source (output valid, output red_level, output green_level,
                   output blue_level, input ready);
   modport sink   (input valid, input red_level, input green_level,
                   input blue_level, output ready);
endinterface

/* hdl/color_temperature_gamma_ramp_core.sv */
// Color temperature gamma ramp core: registers, valid pipeline and lanes.
// Depends on ctr_pkg, ctr_ifs, ctr_gain, ctr_lane and the macros header.
`include "color_temperature_gamma_ramp_core_macros.svh"

// Takes one ramp index word per cycle and returns the red, green and blue
// ramp entries through the lane pipeline, one word per cycle; a stall at the output
// holds the whole pipeline. The three channel gains come from a sequencer
// around a shared one-bit-per-cycle divider: after reset and after every
// register write it runs again, and req_ch.ready stays low
// until it finishes. Registers: temperature_kelvin at 0x0, ramp_size at 0x4
// (clamped to 2..min(MAX_RAMP_SIZE, 8191)). A level that overflows 16 bits saturates.
module color_temperature_gamma_ramp_core import ctr_pkg::*; #(
   parameter int MAX_RAMP_SIZE = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   ctr_req_if.sink     req_ch,
   ctr_rsp_if.source   rsp_ch
);
   localparam int MAX_RS = (MAX_RAMP_SIZE > 8191) ? 8191 : MAX_RAMP_SIZE;

   logic [KELVIN_W-1:0]  kelvin_ff, kelvin_in;
   logic [RSIZE_W-1:0]   rsize_ff, rsize_in;
   logic [LANE_LAT-1:0]  vld_ff, vld_in;
   logic                 cfg_wr;
   logic [RSIZE_W-1:0]   rs_wr;
   logic                 en;
   logic [DIVISOR_W-1:0] divisor;
   gains_type            gains;
   logic                 gains_in_range;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign rs_wr  = pwdata[RSIZE_W-1:0];
   assign prdata = (paddr[2] == REG_RSIZE) ? {19'b0, rsize_ff} : {18'b0, kelvin_ff};

   always_comb begin
      kelvin_in = kelvin_ff;
      rsize_in  = rsize_ff;
      if (cfg_wr) begin
         if (paddr[2] == REG_KELVIN) begin
            kelvin_in = pwdata[KELVIN_W-1:0];
         end else if (rs_wr < 13'd2) begin
            rsize_in = 13'd2;
         end else if (rs_wr > RSIZE_W'(MAX_RS)) begin
            rsize_in = RSIZE_W'(MAX_RS);
         end else begin
            rsize_in = rs_wr;
         end
      end
   end

   // advance unless a finished word waits at the output and is not taken
   assign en           = !vld_ff[LANE_LAT-1] || rsp_ch.ready;
   assign req_ch.ready = en && gains.ok;
   assign vld_in       = {vld_ff[LANE_LAT-2:0], req_ch.valid && req_ch.ready};
   assign rsp_ch.valid = vld_ff[LANE_LAT-1];
   assign divisor      = {rsize_ff, 8'b0} - {8'b0, rsize_ff};

   assign gains_in_range = (gains.red <= GAIN_MAX) && (gains.green <= GAIN_MAX) &&
                           (gains.blue <= GAIN_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         kelvin_ff <= K_RESET;
         rsize_ff  <= RSIZE_RESET;
         vld_ff    <= '0;
      end else begin
         kelvin_ff <= kelvin_in;
         rsize_ff  <= rsize_in;
         if (en) begin
            vld_ff <= vld_in;
         end
      end
   end

   ctr_gain u_gain (
      .clock   (clock),
      .reset   (reset),
      .restart (cfg_wr),
      .kelvin  (kelvin_ff),
      .gains   (gains)
   );

   ctr_lane u_red (
      .clock   (clock),
      .en      (en),
      .idx     (req_ch.ramp_index),
      .gain    (gains.red),
      .divisor (divisor),
      .level   (rsp_ch.red_level)
   );

   ctr_lane u_green (
      .clock   (clock),
      .en      (en),
      .idx     (req_ch.ramp_index),
      .gain    (gains.green),
      .divisor (divisor),
      .level   (rsp_ch.green_level)
   );

   ctr_lane u_blue (
      .clock   (clock),
      .en      (en),
      .idx     (req_ch.ramp_index),
      .gain    (gains.blue),
      .divisor (divisor),
      .level   (rsp_ch.blue_level)
   );

   `CTR_ASSERT_IMPL(a_busy_blocks_req, clock, reset, !gains.ok, !req_ch.ready)
   `CTR_ASSERT_NEXT(a_write_restarts, clock, reset, cfg_wr, !gains.ok)
   `CTR_ASSERT_IMPL(a_gain_range, clock, reset, gains.ok, gains_in_range)
endmodule

/* hdl/ctr_div.sv */
// Iterative restoring divider, one quotient bit per cycle, for the gain unit.
// Depends on ctr_pkg for operand widths.
module ctr_div import ctr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic [DIV_NUM_W-1:0] quot,
   output logic                 done
);
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   rem2;
   logic [DIV_DEN_W:0]   diff;
   logic                 ge;

   always_comb begin
      rem2    = {rem_ff, num_ff[DIV_NUM_W-1]};
      diff    = rem2 - {1'b0, den_ff};
      ge      = rem2 >= {1'b0, den_ff};
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = done_ff;
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = 6'(DIV_STEPS);
         run_in  = 1'b1;
         done_in = 1'b0;
      end else if (run_ff) begin
         num_in = {num_ff[DIV_NUM_W-2:0], ge};
         rem_in = ge ? diff[DIV_DEN_W-1:0] : rem2[DIV_DEN_W-1:0];
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign quot = num_ff;
   assign done = done_ff;
endmodule

/* hdl/ctr_gain.sv */
// Gain sequencer: turns the white-point temperature into three Q8.16 gains
// with a + b*t + c*ln(t). Depends on ctr_pkg and ctr_div.
module ctr_gain import ctr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                restart,
   input  logic [KELVIN_W-1:0] kelvin,
   output gains_type           gains
);
   gain_state_type     state_ff, state_in;
   logic [1:0]         ch_ff, ch_in;
   fit_type            fit_ff, fit_in;
   logic signed [24:0] t_ff, t_in;
   logic [23:0]        m_ff, m_in;
   logic signed [5:0]  e_ff, e_in;
   logic [29:0]        z2_ff, z2_in;
   logic [29:0]        pw_ff, pw_in;
   logic [30:0]        acc_ff, acc_in;
   logic [3:0]         kd_ff, kd_in;
   logic signed [23:0] ln_ff, ln_in;
   logic signed [45:0] p1_ff, p1_in;
   logic signed [51:0] p2_ff, p2_in;
   logic [GAIN_W-1:0]  gr_ff, gr_in, gg_ff, gg_in, gb_ff, gb_in;
   logic               ok_ff, ok_in;

   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [DIV_NUM_W-1:0] div_q;
   logic                 div_done;

   logic                 store;
   logic [GAIN_W-1:0]    store_val;
   logic [42:0]          kq_prod;
   logic signed [24:0]   t_new;
   logic [59:0]          zz;
   logic [59:0]          pp;
   logic [30:0]          kd_recip;
   logic [60:0]          kp;
   logic [29:0]          kd_q;
   logic signed [37:0]   r;
   logic signed [53:0]   sum;

   ctr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quot  (div_q),
      .done  (div_done)
   );

   always_comb begin
      state_in  = state_ff;
      ch_in     = ch_ff;
      fit_in    = fit_ff;
      t_in      = t_ff;
      m_in      = m_ff;
      e_in      = e_ff;
      z2_in     = z2_ff;
      pw_in     = pw_ff;
      acc_in    = acc_ff;
      kd_in     = kd_ff;
      ln_in     = ln_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      gr_in     = gr_ff;
      gg_in     = gg_ff;
      gb_in     = gb_ff;
      ok_in     = ok_ff;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      store     = 1'b0;
      store_val = '0;
      // kelvin*65536/100 = kelvin*16384/25, by reciprocal multiply
      kq_prod   = kelvin * KDIV25_RECIP;
      t_new     = $signed({1'b0, kq_prod[42:19]}) - $signed({3'b0, fit_ff.off, 16'b0});
      zz        = div_q[29:0] * div_q[29:0];
      pp        = pw_ff * z2_ff;
      case (kd_ff)
         4'd3:    kd_recip = RECIP_3;
         4'd5:    kd_recip = RECIP_5;
         4'd7:    kd_recip = RECIP_7;
         default: kd_recip = RECIP_9;
      endcase
      kp        = pw_ff * kd_recip;
      case (kd_ff)
         4'd3:    kd_q = {1'b0, kp[60:32]};
         4'd5:    kd_q = {2'b0, kp[60:33]};
         4'd7:    kd_q = {2'b0, kp[60:33]};
         default: kd_q = {3'b0, kp[60:34]};
      endcase
      r         = 38'(e_ff * $signed({1'b0, LN2_Q30})) + $signed({6'b0, acc_ff, 1'b0});
      sum       = 54'($signed({fit_ff.a, 16'b0})) + 54'(p1_ff) + 54'(p2_ff);

      case (state_ff)
         ST_CH: begin
            // pick the band; constant gains skip the fit
            case (ch_ff)
               CH_RED: begin
                  if (kelvin <= K_WARM) begin
                     store     = 1'b1;
                     store_val = GAIN_MAX;
                  end else begin
                     fit_in    = RED_FIT;
                     state_in  = ST_TCALC;
                  end
               end
               CH_GREEN: begin
                  fit_in    = (kelvin <= K_WARM) ? GREEN_LO : GREEN_HI;
                  state_in  = ST_TCALC;
               end
               default: begin
                  if (kelvin <= K_BLUE_LO) begin
                     store     = 1'b1;
                     store_val = '0;
                  end else if (kelvin < K_WARM) begin
                     fit_in    = BLUE_FIT;
                     state_in  = ST_TCALC;
                  end else begin
                     store     = 1'b1;
                     store_val = GAIN_MAX;
                  end
               end
            endcase
         end
         ST_TCALC: begin
            t_in = t_new;
            if (t_new <= 25'sd0) begin
               store     = 1'b1;
               store_val = '0;
            end else begin
               m_in     = t_new[23:0];
               e_in     = '0;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            // bring the mantissa into [1,2) one bit a cycle
            if (|m_ff[23:17]) begin
               m_in = {1'b0, m_ff[23:1]};
               e_in = e_ff + 6'sd1;
            end else if (!m_ff[16]) begin
               m_in = {m_ff[22:0], 1'b0};
               e_in = e_ff - 6'sd1;
            end else begin
               div_num   = {1'b0, m_ff[15:0], 30'b0};
               div_den   = 18'(m_ff[16:0]) + 18'd65536;
               div_start = 1'b1;
               state_in  = ST_ZDIV;
            end
         end
         ST_ZDIV: begin
            if (div_done) begin
               state_in = ST_Z2;
            end
         end
         ST_Z2: begin
            z2_in    = zz[59:30];
            pw_in    = div_q[29:0];
            acc_in   = {1'b0, div_q[29:0]};
            kd_in    = 4'd3;
            state_in = ST_PW;
         end
         ST_PW: begin
            pw_in    = pp[59:30];
            state_in = ST_KDIV;
         end
         ST_KDIV: begin
            acc_in = acc_ff + {1'b0, kd_q};
            if (kd_ff == 4'd9) begin
               state_in = ST_LN;
            end else begin
               kd_in    = kd_ff + 4'd2;
               state_in = ST_PW;
            end
         end
         ST_LN: begin
            ln_in    = r[37:14];
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            p1_in    = fit_ff.b * t_ff;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            p2_in    = fit_ff.c * ln_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            store = 1'b1;
            if (sum[53]) begin
               store_val = '0;
            end else if (sum[52:20] > 33'(GAIN_MAX)) begin
               store_val = GAIN_MAX;
            end else begin
               store_val = sum[43:20];
            end
         end
         ST_IDLE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (store) begin
         case (ch_ff)
            CH_RED:   gr_in = store_val;
            CH_GREEN: gg_in = store_val;
            default:  gb_in = store_val;
         endcase
         if (ch_ff == CH_BLUE) begin
            ok_in    = 1'b1;
            state_in = ST_IDLE;
         end else begin
            ch_in    = ch_ff + 2'd1;
            state_in = ST_CH;
         end
      end

      if (restart) begin
         state_in = ST_CH;
         ch_in    = CH_RED;
         ok_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      fit_ff <= fit_in;
      t_ff   <= t_in;
      m_ff   <= m_in;
      e_ff   <= e_in;
      z2_ff  <= z2_in;
      pw_ff  <= pw_in;
      acc_ff <= acc_in;
      kd_ff  <= kd_in;
      ln_ff  <= ln_in;
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      gr_ff  <= gr_in;
      gg_ff  <= gg_in;
      gb_ff  <= gb_in;
      if (reset) begin
         state_ff <= ST_CH;
         ch_ff    <= CH_RED;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         ok_ff    <= ok_in;
      end
   end

   assign gains.ok    = ok_ff;
   assign gains.red   = gr_ff;
   assign gains.green = gg_ff;
   assign gains.blue  = gb_ff;
endmodule

/* hdl/ctr_lane.sv */
// One color channel of the ramp pipeline: index times gain, then a
// one-bit-per-stage division by ramp_size*255. Depends on ctr_pkg.
module ctr_lane import ctr_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic [IDX_W-1:0]     idx,
   input  logic [GAIN_W-1:0]    gain,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic [LEVEL_W-1:0]   level
);
   localparam int QBITS = LEVEL_W;

   logic [35:0]          prod_ff;
   logic [35:0]          n_ff;
   logic [51:0]          scaled;
   logic                 sat_ff [QBITS+1];
   logic [DIVISOR_W-1:0] rem_ff [QBITS+1];
   logic [QBITS-1:0]     nlo_ff [QBITS+1];
   logic [QBITS-1:0]     q_ff   [QBITS+1];

   // times 65535 then drop the 2^16 factor of the divisor
   assign scaled = {prod_ff, 16'b0} - {16'b0, prod_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= 36'(idx * gain);
         n_ff      <= scaled[51:16];
         sat_ff[0] <= {1'b0, n_ff} >= {divisor, 16'b0};
         rem_ff[0] <= {1'b0, n_ff[35:16]};
         nlo_ff[0] <= n_ff[15:0];
         q_ff[0]   <= '0;
      end
   end

   for (genvar j = 0; j < QBITS; j++) begin : g_stage
      logic [DIVISOR_W:0] rem2;
      logic [DIVISOR_W:0] diff;
      logic               ge;
      assign rem2 = {rem_ff[j], nlo_ff[j][QBITS-1-j]};
      assign diff = rem2 - {1'b0, divisor};
      assign ge   = rem2 >= {1'b0, divisor};
      always_ff @(posedge clock) begin
         if (en) begin
            sat_ff[j+1] <= sat_ff[j];
            nlo_ff[j+1] <= nlo_ff[j];
            rem_ff[j+1] <= ge ? diff[DIVISOR_W-1:0] : rem2[DIVISOR_W-1:0];
            q_ff[j+1]   <= {q_ff[j][QBITS-2:0], ge};
         end
      end
   end

   assign level = sat_ff[QBITS] ? {LEVEL_W{1'b1}} : q_ff[QBITS];
endmodule
